/* design/ccs_pkg.sv */
// Shared types, constants and state codes of the covariance chi-square core.
`timescale 1ns / 1ps

package ccs_pkg;

    // Fixed field widths of the command and result words.
    localparam int CCS_FIELD_W = 32;
    localparam int CCS_IDX_W   = 6;
    localparam int CCS_BINS_W  = 7;
    localparam int CCS_ACC_W   = 64;
    localparam int CCS_FRAC_W  = 16;
    localparam int CCS_HALF_W  = 32;

    // Defaults for the top-level parameters.
    localparam int CCS_MAX_BINS_DEF = 64;
    localparam int CCS_VALUE_W_DEF  = 32;

    // Configuration port.
    localparam int                    CCS_APB_AW     = 2;
    localparam int                    CCS_APB_DW     = 32;
    localparam logic [CCS_APB_AW-1:0] CCS_REG_BINS   = 2'd0;
    localparam logic [CCS_BINS_W-1:0] CCS_BINS_RESET = 7'd1;

    // Command codes.
    localparam logic CCS_OP_MATRIX = 1'b0;
    localparam logic CCS_OP_BIN    = 1'b1;

    // Saturation limits of the 64-bit accumulators.
    localparam logic signed [CCS_ACC_W-1:0] CCS_ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [CCS_ACC_W-1:0] CCS_ACC_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic                          op;
        logic        [CCS_IDX_W-1:0]   row_index;
        logic        [CCS_IDX_W-1:0]   col_index;
        logic signed [CCS_FIELD_W-1:0] matrix_value;
        logic signed [CCS_FIELD_W-1:0] observed;
        logic signed [CCS_FIELD_W-1:0] background;
        logic signed [CCS_FIELD_W-1:0] prediction;
        logic                          last;
    } t_cmd;

    typedef struct packed {
        logic signed [CCS_ACC_W-1:0] chi_square;
        logic                        saturated;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_FIN_LO,
        S_FIN_HI,
        S_FIN_SUM,
        S_FIN_ACC
    } t_state;

endpackage

/* design/ccs_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module ccs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/covariance_chi_square_core.sv */
// Top level of the covariance chi-square core: squared Mahalanobis distance r'Mr.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                    Word
// command   in         start high, busy low         i_cmd (t_cmd)
// result    out        o_result_valid, one cycle    o_result (t_result)
// config    in/out     APB write, pready always 1   bins_in_use at byte address 0
//
// Matrix-write words and bin words without last are taken one per cycle while busy is low.
// A bin word with last starts a walk over n = min(bins_in_use, MAX_BINS) rows;
// each row multiplies its n matrix entries with the residuals, drains the
// multiplier pipeline and folds the row into the total through FIN_LO,
// FIN_HI, FIN_SUM and FIN_ACC; the result strobe comes in the cycle busy
// falls. The walk is set by the single read port of the matrix RAM.
// With n equal to zero the result strobes in the next cycle without busy.
// Reset is synchronous and active low; it clears control state only, while
// the matrix and residual RAMs hold undefined data until written.
// The receiver cannot stall results, so no back pressure exists.

module covariance_chi_square_core
    import ccs_pkg::*;
#(
    parameter int MAX_BINS    = CCS_MAX_BINS_DEF,
    parameter int VALUE_WIDTH = CCS_VALUE_W_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Command channel
    input  logic                  start,
    output logic                  busy,
    input  t_cmd                  i_cmd,
    // Result channel
    output logic                  o_result_valid,
    output t_result               o_result,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CCS_APB_AW-1:0] paddr,
    input  logic [CCS_APB_DW-1:0] pwdata,
    output logic [CCS_APB_DW-1:0] prdata,
    output logic                  pready
);

    // Widths derived from the parameters.
    localparam int VW     = VALUE_WIDTH;
    localparam int IDX_W  = $clog2(MAX_BINS);
    localparam int CNT_W  = $clog2(MAX_BINS + 1);
    localparam int NW     = (CNT_W > CCS_BINS_W) ? CNT_W : CCS_BINS_W;
    localparam int AW     = $clog2(MAX_BINS * MAX_BINS);
    // Multiplier: the A operand also carries the halves of a row sum, so it is at least 33 bits wide.
    localparam int MW     = (VW > CCS_HALF_W + 1) ? VW : CCS_HALF_W + 1;
    localparam int PW     = MW + VW;
    // Rescaled matrix-times-residual product, at least the accumulator width.
    localparam int M1W    = (2 * VW - CCS_FRAC_W > CCS_ACC_W) ?
                            2 * VW - CCS_FRAC_W : CCS_ACC_W;
    // Full product of a 64-bit row sum with a residual.
    localparam int FW     = CCS_ACC_W + VW + 1;
    localparam int RW     = VW + 2;

    localparam logic [AW-1:0]        ROW_STRIDE = AW'(MAX_BINS);
    localparam logic signed [VW-1:0] VAL_MAX    = {1'b0, {(VW - 1){1'b1}}};
    localparam logic signed [VW-1:0] VAL_MIN    = {1'b1, {(VW - 1){1'b0}}};

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state                   r_state, n_state;
    logic [CCS_BINS_W-1:0]    r_bins;
    logic [IDX_W-1:0]         r_row, n_row;
    logic [IDX_W-1:0]         r_col, n_col;
    logic [IDX_W-1:0]         r_last_idx, n_last_idx;
    logic signed [CCS_ACC_W-1:0] r_part, n_part;
    logic signed [CCS_ACC_W-1:0] r_total, n_total;
    logic                     r_ovf, n_ovf;
    logic                     r_v1, r_v2;
    logic [IDX_W-1:0]         r_col1;
    logic signed [VW-1:0]     r_ri;
    logic signed [PW-1:0]     r_prod;
    logic signed [PW-1:0]     r_pp_lo;
    logic signed [CCS_ACC_W-1:0] r_term;
    logic                     r_out_valid, n_out_valid;
    t_result                  r_out, n_out;

    // ------------------------------------------------------------------
    // Command decode and residual
    // ------------------------------------------------------------------
    logic                     w_accept;
    logic                     w_row_ok, w_col_ok;
    logic [IDX_W-1:0]         w_row_a, w_col_a;
    logic signed [VW-1:0]     w_obs, w_bkg, w_pred;
    logic signed [RW-1:0]     w_diff;
    logic                     w_res_ovf;
    logic signed [VW-1:0]     w_res;
    logic [NW-1:0]            w_bins_ext, w_n;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    assign w_row_ok = (32'(i_cmd.row_index) < 32'(MAX_BINS));
    assign w_col_ok = (32'(i_cmd.col_index) < 32'(MAX_BINS));
    assign w_row_a  = IDX_W'(i_cmd.row_index);
    assign w_col_a  = IDX_W'(i_cmd.col_index);

    // Residual = observed - background - prediction, clamped to the value range.
    assign w_obs     = VW'(i_cmd.observed);
    assign w_bkg     = VW'(i_cmd.background);
    assign w_pred    = VW'(i_cmd.prediction);
    assign w_diff    = RW'(w_obs) - RW'(w_bkg) - RW'(w_pred);
    assign w_res_ovf = (w_diff[RW-1:VW-1] != {3{w_diff[VW-1]}});
    assign w_res     = w_res_ovf ? (w_diff[RW-1] ? VAL_MIN : VAL_MAX) : w_diff[VW-1:0];

    // Effective dimension: bins_in_use clipped to MAX_BINS.
    assign w_bins_ext = NW'(r_bins);
    assign w_n        = (w_bins_ext > NW'(MAX_BINS)) ? NW'(MAX_BINS) : w_bins_ext;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic               w_mat_we, w_res_we;
    logic [AW-1:0]      w_mat_waddr, w_mat_raddr;
    logic [VW-1:0]      w_mat_rdata, w_res_rdata;

    assign w_mat_we    = w_accept && (i_cmd.op == CCS_OP_MATRIX) && w_row_ok && w_col_ok;
    assign w_res_we    = w_accept && (i_cmd.op == CCS_OP_BIN) && w_row_ok;
    assign w_mat_waddr = AW'(w_row_a) * ROW_STRIDE + AW'(w_col_a);
    assign w_mat_raddr = AW'(r_row) * ROW_STRIDE + AW'(r_col);

    ccs_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_BINS * MAX_BINS)
    ) u_mat_ram (
        .i_clk   (i_clk),
        .i_we    (w_mat_we),
        .i_waddr (w_mat_waddr),
        .i_wdata (VW'(i_cmd.matrix_value)),
        .i_raddr (w_mat_raddr),
        .o_rdata (w_mat_rdata)
    );

    ccs_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_BINS)
    ) u_res_ram (
        .i_clk   (i_clk),
        .i_we    (w_res_we),
        .i_waddr (w_row_a),
        .i_wdata (w_res),
        .i_raddr (r_col),
        .o_rdata (w_res_rdata)
    );

    // ------------------------------------------------------------------
    // Shared multiplier. During the walk it takes a matrix entry and a
    // residual; when a row is folded in it takes the low (unsigned) and
    // then the high (signed) half of the row sum against r[row].
    // ------------------------------------------------------------------
    logic signed [MW-1:0] w_mul_a;
    logic signed [VW-1:0] w_mul_b;
    logic signed [PW-1:0] w_mul_p;

    always_comb begin
        unique case (r_state)
            S_FIN_LO: begin
                w_mul_a = MW'($signed({1'b0, r_part[CCS_HALF_W-1:0]}));
                w_mul_b = r_ri;
            end
            S_FIN_HI: begin
                w_mul_a = MW'($signed(r_part[CCS_ACC_W-1:CCS_HALF_W]));
                w_mul_b = r_ri;
            end
            default: begin
                w_mul_a = MW'($signed(w_mat_rdata));
                w_mul_b = $signed(w_res_rdata);
            end
        endcase
    end

    assign w_mul_p = PW'(w_mul_a) * PW'(w_mul_b);

    // Rescale a matrix-times-residual product and add it to the row sum.
    logic signed [PW-1:0]        w_mac_shift;
    logic signed [M1W-1:0]       w_mac_ext;
    logic                        w_mac_ovf;
    logic signed [CCS_ACC_W-1:0] w_mac_term;
    logic signed [CCS_ACC_W:0]   w_mac_sum;
    logic                        w_mac_add_ovf;
    logic signed [CCS_ACC_W-1:0] w_mac_res;

    assign w_mac_shift   = r_prod >>> CCS_FRAC_W;
    assign w_mac_ext     = M1W'(w_mac_shift);
    assign w_mac_ovf     = (w_mac_ext[M1W-1:CCS_ACC_W-1] !=
                            {(M1W - CCS_ACC_W + 1){w_mac_ext[CCS_ACC_W-1]}});
    assign w_mac_term    = w_mac_ovf ? (w_mac_ext[M1W-1] ? CCS_ACC_MIN : CCS_ACC_MAX)
                                     : w_mac_ext[CCS_ACC_W-1:0];
    assign w_mac_sum     = (CCS_ACC_W + 1)'(r_part) + (CCS_ACC_W + 1)'(w_mac_term);
    assign w_mac_add_ovf = (w_mac_sum[CCS_ACC_W] != w_mac_sum[CCS_ACC_W-1]);
    assign w_mac_res     = w_mac_add_ovf ?
                           (w_mac_sum[CCS_ACC_W] ? CCS_ACC_MIN : CCS_ACC_MAX)
                           : w_mac_sum[CCS_ACC_W-1:0];

    // Join the two half products of row sum times r[row] and rescale.
    logic signed [FW-1:0]        w_fin_full;
    logic signed [FW-1:0]        w_fin_shift;
    logic                        w_fin_ovf;
    logic signed [CCS_ACC_W-1:0] w_fin_term;

    assign w_fin_full  = (FW'(r_prod) <<< CCS_HALF_W) + FW'(r_pp_lo);
    assign w_fin_shift = w_fin_full >>> CCS_FRAC_W;
    assign w_fin_ovf   = (w_fin_shift[FW-1:CCS_ACC_W-1] !=
                          {(FW - CCS_ACC_W + 1){w_fin_shift[CCS_ACC_W-1]}});
    assign w_fin_term  = w_fin_ovf ? (w_fin_shift[FW-1] ? CCS_ACC_MIN : CCS_ACC_MAX)
                                   : w_fin_shift[CCS_ACC_W-1:0];

    // Fold the row term into the total.
    logic signed [CCS_ACC_W:0]   w_acc_sum;
    logic                        w_acc_ovf;
    logic signed [CCS_ACC_W-1:0] w_acc_res;

    assign w_acc_sum = (CCS_ACC_W + 1)'(r_total) + (CCS_ACC_W + 1)'(r_term);
    assign w_acc_ovf = (w_acc_sum[CCS_ACC_W] != w_acc_sum[CCS_ACC_W-1]);
    assign w_acc_res = w_acc_ovf ? (w_acc_sum[CCS_ACC_W] ? CCS_ACC_MIN : CCS_ACC_MAX)
                                 : w_acc_sum[CCS_ACC_W-1:0];

    // ------------------------------------------------------------------
    // Sequencer: next state and control
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_last_idx  = r_last_idx;
        n_part      = r_part;
        n_total     = r_total;
        n_ovf       = r_ovf;
        n_out_valid = 1'b0;
        n_out       = r_out;

        // The multiplier pipeline folds finished products into the row sum.
        if (r_v2) begin
            n_part = w_mac_res;
            n_ovf  = r_ovf | w_mac_ovf | w_mac_add_ovf;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_cmd.op == CCS_OP_BIN)) begin
                    n_ovf = r_ovf | w_res_ovf;
                    if (i_cmd.last) begin
                        if (w_n == '0) begin
                            // Empty sum: report zero at once.
                            n_out_valid          = 1'b1;
                            n_out.chi_square     = '0;
                            n_out.saturated      = r_ovf | w_res_ovf;
                            n_ovf                = 1'b0;
                        end else begin
                            n_state    = S_WALK;
                            n_row      = '0;
                            n_col      = '0;
                            n_part     = '0;
                            n_total    = '0;
                            n_last_idx = IDX_W'(w_n - NW'(1));
                        end
                    end
                end
            end
            S_WALK: begin
                if (r_col == r_last_idx) begin
                    n_col   = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_col = r_col + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = S_FIN_LO;
                end
            end
            S_FIN_LO: begin
                n_state = S_FIN_HI;
            end
            S_FIN_HI: begin
                n_state = S_FIN_SUM;
            end
            S_FIN_SUM: begin
                n_ovf   = r_ovf | w_fin_ovf;
                n_state = S_FIN_ACC;
            end
            S_FIN_ACC: begin
                n_part = '0;
                if (r_row == r_last_idx) begin
                    n_out_valid      = 1'b1;
                    n_out.chi_square = w_acc_res;
                    n_out.saturated  = r_ovf | w_acc_ovf;
                    n_total          = '0;
                    n_ovf            = 1'b0;
                    n_row            = '0;
                    n_state          = S_IDLE;
                end else begin
                    n_total = w_acc_res;
                    n_ovf   = r_ovf | w_acc_ovf;
                    n_row   = r_row + IDX_W'(1);
                    n_state = S_WALK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_part      <= '0;
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_part      <= n_part;
            r_total     <= n_total;
            r_ovf       <= n_ovf;
            r_v1        <= (r_state == S_WALK);
            r_v2        <= r_v1;
            r_out_valid <= n_out_valid;
        end
    end

    // Data path registers.
    always_ff @(posedge i_clk) begin
        r_last_idx <= n_last_idx;
        r_out      <= n_out;
        r_col1     <= r_col;
        r_prod     <= w_mul_p;
        r_term     <= w_fin_term;
        // r[row] passes by on the diagonal column of each row.
        if (r_v1 && (r_col1 == r_row)) begin
            r_ri <= $signed(w_res_rdata);
        end
        if (r_state == S_FIN_HI) begin
            r_pp_lo <= r_prod;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bins <= CCS_BINS_RESET;
        end else if (psel && penable && pwrite && (paddr == CCS_REG_BINS)) begin
            r_bins <= pwdata[CCS_BINS_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == CCS_REG_BINS) ? CCS_APB_DW'(r_bins) : '0;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A result is only strobed while the core is idle.
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobed while busy");

    // Whenever the core is idle the multiplier pipeline is empty.
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> (!r_v1 && !r_v2))
        else $error("multiplier pipeline active while idle");

    // A final bin word either starts a walk or yields a result next cycle.
    a_last_reacts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd.op == CCS_OP_BIN) && i_cmd.last)
        |=> (busy || o_result_valid))
        else $error("final bin word produced no reaction");

    // Walk indices stay inside the active matrix.
    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ((r_col <= r_last_idx) && (r_row <= r_last_idx)))
        else $error("walk index beyond the active dimension");

endmodule
